// File: rtl/strt_pkg.sv
// Package for the space-time reservation table unit.
// Holds request/status codes, the sequencer state type and payload structs.
// No dependencies.
package strt_pkg;

   localparam logic [1:0] REQ_RESERVE = 2'd0;
   localparam logic [1:0] REQ_RELEASE = 2'd1;
   localparam logic [1:0] REQ_CHECK   = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_RANGE    = 2'd1;
   localparam logic [1:0] ST_MISMATCH = 2'd2;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_RD1,
      S_RD2,
      S_RD3,
      S_EVAL,
      S_SCAN,
      S_OUT
   } state_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] agent;
      logic [9:0] location;
      logic [9:0] from_location;
      logic [7:0] time_step;
      logic       last_point;
   } req_type_type;

   typedef struct packed {
      logic [1:0] status;
      logic       vertex_conflict;
      logic       edge_conflict;
      logic       target_conflict;
      logic [7:0] vertex_agent;
      logic [7:0] edge_agent;
      logic [7:0] makespan_now;
   } rsp_type;

endpackage

// File: rtl/strt_if.sv
// Valid/ready channel interface used for the request and response channels.
// Depends on nothing but the payload type given as a parameter.
interface strt_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/space_time_reservation_table_unit.sv
// Space-time reservation table for multi-agent path planning.
// Request channel req (sink): reserve, release or check one path point or move.
// Response channel rsp (source): one response transaction per request.
// Each request is handled alone. A reserve only writes, a release reads the cell
// and then clears it, and a check reads three cells one after another (one when
// the arrival time is zero), since the cell memory has one read port.
// A release of a goal point that held the makespan rescans the goal memory,
// one location per cycle.
// After reset the block sweeps both memories clear, one entry per cycle,
// while req_ready stays low.
// The response waits in an output register while rsp_ready is low; the next
// request is taken in the same cycle the response is taken.
// Range errors answer status 1 without touching state.
// Cell entries: bit 8 valid, bits 7..0 agent. Goal entries: bit 8 valid,
// bits 7..0 goal time.
module space_time_reservation_table_unit #(
   parameter int NUM_LOCATIONS = 1024,
   parameter int HORIZON       = 256,
   parameter int NUM_AGENTS    = 256
) (
   input  logic clock,
   input  logic reset,
   strt_if.sink   req,
   strt_if.source rsp
);
   localparam int LW    = (NUM_LOCATIONS > 1) ? $clog2(NUM_LOCATIONS) : 1;
   localparam int TW    = (HORIZON > 1) ? $clog2(HORIZON) : 1;
   localparam int AW    = LW + TW;
   localparam int DEPTH = NUM_LOCATIONS * HORIZON;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int GW    = $clog2(NUM_LOCATIONS + 1);

   strt_pkg::state_type    state_ff, state_in;
   strt_pkg::req_type_type q_ff, q_in;
   strt_pkg::rsp_type      r_ff, r_in;
   logic [CW-1:0] clr_ff, clr_in;
   logic [GW-1:0] scan_ff, scan_in;
   logic [7:0]    mk_ff, mk_in, best_ff, best_in;
   logic [8:0]    prev_ff, prev_in;

   logic [8:0] cell_mem [DEPTH];
   logic [8:0] goal_mem [NUM_LOCATIONS];
   logic [8:0] cell_rd, goal_rd;
   logic          c_we, g_we;
   logic [AW-1:0] c_addr;
   logic [8:0]    c_wd, g_wd;
   logic [LW-1:0] g_addr;

   // 32-bit widened request fields for range tests
   logic bad;
   always_comb begin
      bad = (32'(q_ff.location) >= 32'(NUM_LOCATIONS)) ||
            (32'(q_ff.time_step) >= 32'(HORIZON));
      if (q_ff.req_type == strt_pkg::REQ_CHECK &&
          32'(q_ff.from_location) >= 32'(NUM_LOCATIONS)) bad = 1'b1;
      if (q_ff.req_type != strt_pkg::REQ_CHECK &&
          32'(q_ff.agent) >= 32'(NUM_AGENTS)) bad = 1'b1;
   end

   function automatic logic [AW-1:0] caddr(logic [9:0] l, logic [7:0] t);
      logic [31:0] a;
      a = 32'(l) * 32'(HORIZON) + 32'(t);
      return a[AW-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (c_we) cell_mem[c_addr] <= c_wd;
      cell_rd <= cell_mem[c_addr];
      if (g_we) goal_mem[g_addr] <= g_wd;
      goal_rd <= goal_mem[g_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= strt_pkg::S_CLEAR;
         clr_ff   <= '0;
         mk_ff    <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         mk_ff    <= mk_in;
      end
      q_ff    <= q_in;
      r_ff    <= r_in;
      scan_ff <= scan_in;
      best_ff <= best_in;
      prev_ff <= prev_in;
   end

   assign rsp.payload = r_ff;

   always_comb begin
      state_in = state_ff;
      q_in = q_ff; r_in = r_ff; clr_in = clr_ff; scan_in = scan_ff;
      mk_in = mk_ff; best_in = best_ff; prev_in = prev_ff;
      c_we = 1'b0; c_wd = '0; c_addr = caddr(q_ff.location, q_ff.time_step);
      g_we = 1'b0; g_wd = '0; g_addr = q_ff.location[LW-1:0];
      req.ready = 1'b0;
      rsp.valid = 1'b0;
      case (state_ff)
         strt_pkg::S_CLEAR: begin
            c_we = 1'b1; c_addr = clr_ff[AW-1:0];
            if (32'(clr_ff) < 32'(NUM_LOCATIONS)) begin
               g_we = 1'b1; g_addr = clr_ff[LW-1:0];
            end
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == DEPTH - 1) state_in = strt_pkg::S_IDLE;
         end
         strt_pkg::S_IDLE, strt_pkg::S_OUT: begin
            rsp.valid = (state_ff == strt_pkg::S_OUT);
            req.ready = !rsp.valid || rsp.ready;
            if (rsp.valid && rsp.ready) state_in = strt_pkg::S_IDLE;
            if (req.valid && req.ready) begin
               q_in = req.payload;
               state_in = strt_pkg::S_RD1;
            end
         end
         strt_pkg::S_RD1: begin
            // issue read of destination cell and goal entry
            r_in = '0;
            r_in.makespan_now = mk_ff;
            if (q_ff.req_type > strt_pkg::REQ_CHECK) state_in = strt_pkg::S_OUT;
            else if (bad) begin
               r_in.status = strt_pkg::ST_RANGE;
               state_in = strt_pkg::S_OUT;
            end else if (q_ff.req_type == strt_pkg::REQ_RESERVE) begin
               c_we = 1'b1; c_wd = {1'b1, q_ff.agent};
               if (q_ff.last_point) begin
                  g_we = 1'b1; g_wd = {1'b1, q_ff.time_step};
                  if (q_ff.time_step > mk_ff) begin
                     mk_in = q_ff.time_step;
                     r_in.makespan_now = q_ff.time_step;
                  end
               end
               state_in = strt_pkg::S_OUT;
            end else state_in = strt_pkg::S_RD2;
         end
         strt_pkg::S_RD2: begin
            if (q_ff.req_type == strt_pkg::REQ_RELEASE) begin
               if (!cell_rd[8] || cell_rd[7:0] != q_ff.agent)
                  r_in.status = strt_pkg::ST_MISMATCH;
               c_we = 1'b1;
               if (q_ff.last_point) begin
                  g_we = 1'b1;
                  if (mk_ff == q_ff.time_step) begin
                     scan_in = '0; best_in = '0;
                     state_in = strt_pkg::S_SCAN;
                  end else state_in = strt_pkg::S_OUT;
               end else state_in = strt_pkg::S_OUT;
            end else begin
               r_in.target_conflict = goal_rd[8] && (goal_rd[7:0] <= q_ff.time_step);
               r_in.vertex_conflict = cell_rd[8];
               r_in.vertex_agent = cell_rd[8] ? cell_rd[7:0] : 8'd0;
               if (q_ff.time_step == 8'd0) state_in = strt_pkg::S_OUT;
               else begin
                  c_addr = caddr(q_ff.location, q_ff.time_step - 8'd1);
                  state_in = strt_pkg::S_RD3;
               end
            end
         end
         strt_pkg::S_RD3: begin
            c_addr = caddr(q_ff.from_location, q_ff.time_step);
            state_in = strt_pkg::S_EVAL;
         end
         strt_pkg::S_EVAL: begin
            // cell_rd now holds the origin cell; prev holds the previous-step cell captured in S_RD3
            if (prev_ff[8] && cell_rd[8] && prev_ff[7:0] == cell_rd[7:0]) begin
               r_in.edge_conflict = 1'b1;
               r_in.edge_agent = cell_rd[7:0];
            end
            state_in = strt_pkg::S_OUT;
         end
         strt_pkg::S_SCAN: begin
            // goal read for scan_ff-1 returns now
            g_addr = scan_ff[LW-1:0];
            if (scan_ff != '0 && goal_rd[8] && goal_rd[7:0] > best_ff)
               best_in = goal_rd[7:0];
            scan_in = scan_ff + 1'b1;
            if (32'(scan_ff) == NUM_LOCATIONS) begin
               mk_in = (goal_rd[8] && goal_rd[7:0] > best_ff) ? goal_rd[7:0] : best_ff;
               r_in.makespan_now = mk_in;
               state_in = strt_pkg::S_OUT;
            end
         end
         default: state_in = strt_pkg::S_IDLE;
      endcase
      // capture the previous-step cell read as it returns in S_RD3
      if (state_ff == strt_pkg::S_RD3) prev_in = cell_rd;
   end
endmodule
